>>> rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, sizes, command codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
	localparam int unsigned WordW      = 32;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;

	localparam logic CmdAbsorb = 1'b0;
	localparam logic CmdFinish = 1'b1;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	function automatic word_t round_k(input logic [5:0] r);
		case (r)
			6'd0: round_k = 32'h428a2f98; 6'd1: round_k = 32'h71374491;
			6'd2: round_k = 32'hb5c0fbcf; 6'd3: round_k = 32'he9b5dba5;
			6'd4: round_k = 32'h3956c25b; 6'd5: round_k = 32'h59f111f1;
			6'd6: round_k = 32'h923f82a4; 6'd7: round_k = 32'hab1c5ed5;
			6'd8: round_k = 32'hd807aa98; 6'd9: round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7; 6'd63: round_k = 32'hc67178f2;
			default: round_k = '0;
		endcase
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		case (i)
			3'd0: init_h = 32'h6a09e667; 3'd1: init_h = 32'hbb67ae85;
			3'd2: init_h = 32'h3c6ef372; 3'd3: init_h = 32'ha54ff53a;
			3'd4: init_h = 32'h510e527f; 3'd5: init_h = 32'h9b05688c;
			3'd6: init_h = 32'h1f83d9ab; 3'd7: init_h = 32'h5be0cd19;
			default: init_h = '0;
		endcase
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/sha_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per enabled cycle, with the 16-word message
// schedule window held as a shift line.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_round (
	input  wire               clk,
	input  wire               load,      // start block: working vars from chain
	input  wire               step,      // run one round
	input  wire               shift_in,  // push a word into the schedule window
	input  sha_pkg::word_t    in_word,
	input  wire [5:0]         rnd,
	input  sha_pkg::word_t    chain [8],
	output sha_pkg::word_t    vars  [8]
);
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t w_q [16];
	sha_pkg::word_t s0, s1, wnew, e, a, big0, big1, ch, maj, t1, t2;

	function automatic sha_pkg::word_t ror(input sha_pkg::word_t x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		e    = v_q[4];
		a    = v_q[0];
		big1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
		ch   = (e & v_q[5]) ^ (~e & v_q[6]);
		t1   = v_q[7] + big1 + ch + sha_pkg::round_k(rnd) + w_q[0];
		big0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
		maj  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + maj;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain[i];
		end else if (step) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (shift_in || step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= shift_in ? in_word : wnew;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) vars[i] = v_q[i];
	end
endmodule
`default_nettype wire

>>> rtl/core/sha256_digest.sv
// ----------------------------------------------------------------------------
// SHA-256 digest
// Byte-stream SHA-256 with padding and 256-bit digest output.
// ----------------------------------------------------------------------------
// channel  dir  tdata                       tuser
// s_axis   in   [7:0] data_byte             [0] cmd
// m_axis   out  [255:0] hash_word_0..7      -
// Absorb: one byte per cycle while ready; bytes pack into a 32-bit word that
// shifts into the schedule window. Every 64th byte starts the rounds and then
// a fold on the shared round unit. Finish: pad bytes are fed at one a cycle
// (up to 72 with an extra block), then rounds, then the digest is held
// until taken. Input is not ready while rounds, padding or output run.
// arst_n clears control and counters and loads the chain words with the IV.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_digest (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  wire         s_axis_tuser,   // [0] cmd
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [255:0] m_axis_tdata   // hash_word_0 at [31:0] .. hash_word_7
);
	sha_pkg::state_t state_q, state_d;
	sha_pkg::word_t  chain_q [8];
	sha_pkg::word_t  vars [8];
	sha_pkg::word_t  pack_q, pack_d;
	logic [5:0]  fill_q, rnd_q;
	logic [63:0] bits_q, total_q;
	logic        fin_q, shift_in, load, step, feed, byte_en;
	logic [7:0]  byte_v;

	// byte stream into block: from input or from padding
	always_comb begin
		feed   = 1'b0;
		byte_v = s_axis_tdata;
		case (state_q)
			sha_pkg::ST_IDLE: feed = s_axis_tvalid && s_axis_tuser == sha_pkg::CmdAbsorb;
			sha_pkg::ST_PAD: begin
				feed   = 1'b1;
				byte_v = fin_q ? 8'h00 : 8'h80;
			end
			sha_pkg::ST_LEN: begin
				feed   = 1'b1;
				byte_v = total_q[63 - {fill_q[2:0], 3'b000} -: 8];
			end
			default: feed = 1'b0;
		endcase
		byte_en  = feed;
		pack_d   = {pack_q[23:0], byte_v};
		shift_in = byte_en && fill_q[1:0] == 2'd3;
		load     = byte_en && fill_q == 6'd63;
		step     = state_q == sha_pkg::ST_ROUND;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::ST_IDLE:
				if (s_axis_tvalid) begin
					if (s_axis_tuser == sha_pkg::CmdFinish) state_d = sha_pkg::ST_PAD;
					else if (fill_q == 6'd63) state_d = sha_pkg::ST_ROUND;
				end
			sha_pkg::ST_PAD:
				if (fill_q == 6'd63) state_d = sha_pkg::ST_ROUND;
				else if (fill_q == 6'd55) state_d = sha_pkg::ST_LEN;
			sha_pkg::ST_LEN:
				if (fill_q == 6'd63) state_d = sha_pkg::ST_ROUND;
			sha_pkg::ST_ROUND:
				if (rnd_q == 6'd63) state_d = sha_pkg::ST_FOLD;
			sha_pkg::ST_FOLD:
				if (!fin_q) state_d = sha_pkg::ST_IDLE;
				else if (total_q[0]) state_d = sha_pkg::ST_OUT;
				else if (fill_q == 6'd56) state_d = sha_pkg::ST_LEN;
				else state_d = sha_pkg::ST_PAD;
			sha_pkg::ST_OUT:
				if (m_axis_tready) state_d = sha_pkg::ST_IDLE;
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	// total_q[0] never set by length (multiple of 8); reused as "length done"
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			fill_q  <= '0;
			rnd_q   <= '0;
			bits_q  <= '0;
			total_q <= '0;
			fin_q   <= 1'b0;
			pack_q  <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::init_h(3'(i));
		end else begin
			state_q <= state_d;
			if (byte_en) begin
				pack_q <= pack_d;
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == sha_pkg::ST_IDLE && s_axis_tvalid) begin
				if (s_axis_tuser == sha_pkg::CmdFinish) begin
					total_q <= bits_q + {55'd0, fill_q, 3'd0};
					fin_q   <= 1'b0;
				end else if (fill_q == 6'd63) begin
					bits_q <= bits_q + 64'd512;
				end
			end
			if (state_q == sha_pkg::ST_PAD) fin_q <= 1'b1;
			if (step) rnd_q <= rnd_q + 6'd1;
			if (state_q == sha_pkg::ST_LEN && fill_q == 6'd63) total_q[0] <= 1'b1;
			if (state_q == sha_pkg::ST_FOLD) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars[i];
				if (fin_q && !total_q[0]) fill_q <= 6'd0;
			end
			if (state_q == sha_pkg::ST_OUT && m_axis_tready) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::init_h(3'(i));
				bits_q  <= '0;
				total_q <= '0;
				fin_q   <= 1'b0;
				fill_q  <= '0;
			end
		end
	end

	sha_round u_round (
		.clk      (clk),
		.load     (load),
		.step     (step),
		.shift_in (shift_in),
		.in_word  (pack_d),
		.rnd      (rnd_q),
		.chain    (chain_q),
		.vars     (vars)
	);

	always_comb begin
		s_axis_tready = state_q == sha_pkg::ST_IDLE;
		m_axis_tvalid = state_q == sha_pkg::ST_OUT;
		for (int i = 0; i < 8; i++) m_axis_tdata[32*i +: 32] = chain_q[i];
	end
endmodule
`default_nettype wire

>>> tb/sha256_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both streams, keeps its own hash state, predicts each digest and
// compares it word by word with what the block emits.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	input  wire          s_axis_tready,
	input  wire [7:0]    s_axis_tdata,
	input  wire          s_axis_tuser,
	input  wire          m_axis_tvalid,
	input  wire          m_axis_tready,
	input  wire [255:0]  m_axis_tdata,
	output int           fail_count,
	output int           pending_digests,
	output int           digest_count,
	output logic         accepted
);
	localparam sha_pkg::word_t IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam sha_pkg::word_t KTAB [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	sha_pkg::word_t hstate [8];
	logic [7:0]   blk [64];
	logic [5:0]   fill;
	logic [63:0]  msg_bits;
	logic [255:0] digest_q [$];

	function automatic sha_pkg::word_t ror(sha_pkg::word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		sha_pkg::word_t w [64];
		sha_pkg::word_t v [8];
		sha_pkg::word_t t1, t2;
		for (int r = 0; r < 16; r++)
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
				+ (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
		v = hstate;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int r = 0; r < 8; r++)
			hstate[r] += v[r];
	endtask

	task automatic restart_message();
		hstate = IV;
		fill = '0;
		msg_bits = '0;
	endtask

	task automatic absorb_request(logic cmd, logic [7:0] b);
		logic [63:0] total;
		int pos;
		logic [255:0] d;
		if (cmd == sha_pkg::CmdAbsorb) begin
			blk[fill] = b;
			fill = fill + 6'd1;
			if (fill == 0) begin
				compress_block();
				msg_bits += 64'd512;
			end
		end else begin
			pos = fill;
			total = msg_bits + 64'(pos) * 8;
			blk[pos] = 8'h80;
			pos++;
			if (pos > 56) begin
				while (pos < 64) blk[pos++] = 8'h00;
				compress_block();
				pos = 0;
			end
			while (pos < 56) blk[pos++] = 8'h00;
			for (int j = 0; j < 8; j++)
				blk[56+j] = total[63-8*j -: 8];
			compress_block();
			for (int j = 0; j < 8; j++)
				d[32*j +: 32] = hstate[j];
			digest_q.push_back(d);
			restart_message();
		end
	endtask

	task automatic report(string what);
		$display("%0t ERROR: %s", $time, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		digest_count = 0;
		pending_digests = 0;
		restart_message();
	end

	always @(posedge clk) begin
		accepted <= arst_n && ((s_axis_tvalid && s_axis_tready)
			|| (m_axis_tvalid && m_axis_tready));
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_request(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				digest_count++;
				if (digest_q.size() == 0)
					report("digest with no request waiting");
				else begin
					for (int j = 0; j < 8; j++)
						if (m_axis_tdata[32*j +: 32] !== digest_q[0][32*j +: 32])
							report($sformatf("digest %0d word %0d got %h want %h", digest_count,
								j, m_axis_tdata[32*j +: 32], digest_q[0][32*j +: 32]));
					void'(digest_q.pop_front());
				end
			end
			pending_digests = digest_q.size();
		end
	end
endmodule

>>> tb/tb_sha256_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest testbench
// Drives byte and finish requests with bursty flow and a stalling receiver;
// the checker predicts digests and counts mismatches.
// ----------------------------------------------------------------------------
module tb_sha256_digest;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic [7:0]   s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tready = 1'b0;
	wire          s_axis_tready;
	wire          m_axis_tvalid;
	wire [255:0]  m_axis_tdata;
	int           fail_count, pending_digests, digest_count;
	logic         accepted;
	int           idle_cycles = 0;
	int           sent = 0;
	bit           hold_off = 1'b0;
	bit           stim_done = 1'b0;

	always #2 clk = ~clk;

	sha256_digest DUT (.*);

	sha256_digest_checker u_checker (.*);

	// receiver: own stall pattern, plus one long hold-off
	always @(negedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
	end

	always @(posedge clk) begin
		idle_cycles = accepted ? 0 : idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("watchdog expired");
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_request(logic cmd, logic [7:0] b, bit gap);
		if (gap && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_message(int len, bit gap);
		for (int i = 0; i < len; i++)
			send_request(sha_pkg::CmdAbsorb, 8'($urandom), gap);
		send_request(sha_pkg::CmdFinish, 8'($urandom), gap);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// empty message, extreme bytes, finish with junk data
		send_request(sha_pkg::CmdFinish, 8'hff, 1'b0);
		send_request(sha_pkg::CmdAbsorb, 8'h00, 1'b0);
		send_request(sha_pkg::CmdAbsorb, 8'hff, 1'b0);
		send_request(sha_pkg::CmdAbsorb, 8'h55, 1'b0);
		send_request(sha_pkg::CmdAbsorb, 8'haa, 1'b0);
		send_request(sha_pkg::CmdFinish, 8'h00, 1'b0);
		// long receiver hold-off while the sender keeps offering
		hold_off = 1'b1;
		fork
			begin
				send_message(0, 1'b0);
				send_message(2, 1'b0);
				send_message(1, 1'b0);
			end
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
		join
		// sender pauses until every digest is back
		s_axis_tvalid <= 1'b0;
		while (pending_digests != 0) @(negedge clk);
		// padding boundaries: 55/56 bytes, full block, two blocks
		send_message(55, 1'b1);
		send_message(56, 1'b1);
		send_message(64, 1'b1);
		send_message(119, 1'b1);
		while (sent < 600) begin
			case ($urandom_range(0, 3))
				0: send_message($urandom_range(0, 8), 1'b1);
				1: send_message($urandom_range(50, 70), 1'b1);
				default: send_message($urandom_range(0, 30), $urandom_range(0, 1));
			endcase
		end
		s_axis_tvalid <= 1'b0;
		while (pending_digests != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Sent %0d requests, checked %0d digests incl. padding edges and stalls.",
			sent, digest_count);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
